// ----- design/matrix4_vector_transform_defines.svh -----
// Assertion macros shared by the matrix transform RTL.
// Both sample on clk and are disabled while rst_n is low.
`ifndef MATRIX4_VECTOR_TRANSFORM_DEFINES_SVH
`define MATRIX4_VECTOR_TRANSFORM_DEFINES_SVH

// Same-cycle implication.
`define M4VT_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define M4VT_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- design/m4vt_pkg.sv -----
package m4vt_pkg;

    localparam int DATA_W = 32;
    localparam int PROD_W = 2 * DATA_W;
    // Vector elements carried by one beat.
    localparam int NVEC   = 4;
    // Room for the sum of NVEC full-precision products.
    localparam int ACC_W  = PROD_W + 2;

    typedef logic signed [DATA_W-1:0] word_t;
    typedef logic signed [PROD_W-1:0] prod_t;
    typedef logic signed [ACC_W-1:0]  acc_t;

    localparam word_t SAT_MAX = 32'sh7FFF_FFFF;
    localparam word_t SAT_MIN = 32'sh8000_0000;

    localparam logic REQ_LOAD      = 1'b0;
    localparam logic REQ_TRANSFORM = 1'b1;

    // Stage load enables handed to every lane.
    typedef struct packed {
        logic s1_en;
        logic s2_en;
    } pipe_ctrl_t;

endpackage

// ----- design/m4vt_lane.sv -----
// One matrix row: products, sum, then shift and clamp.
module m4vt_lane #(
    parameter int NTERM     = 4,
    parameter int FRAC_BITS = 16
) (
    input  logic                 clk,
    input  m4vt_pkg::pipe_ctrl_t ctrl,
    input  m4vt_pkg::word_t      row_elem [NTERM],
    input  m4vt_pkg::word_t      vec_elem [NTERM],
    output m4vt_pkg::word_t      word,
    output logic                 clamp
);

    m4vt_pkg::prod_t prod_reg [NTERM];
    m4vt_pkg::acc_t  acc_reg;
    m4vt_pkg::acc_t  acc_next;
    m4vt_pkg::acc_t  shifted;
    logic [m4vt_pkg::ACC_W-m4vt_pkg::DATA_W:0] top_bits;

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < NTERM; i++)
        begin
            if (ctrl.s1_en)
            begin
                prod_reg[i] <= row_elem[i] * vec_elem[i];
            end
        end
        if (ctrl.s2_en)
        begin
            acc_reg <= acc_next;
        end
    end

    always_comb
    begin
        acc_next = '0;
        for (int i = 0; i < NTERM; i++)
        begin
            acc_next = acc_next + m4vt_pkg::ACC_W'(prod_reg[i]);
        end
    end

    // Arithmetic shift rounds toward minus infinity.
    assign shifted  = acc_reg >>> FRAC_BITS;
    assign top_bits = shifted[m4vt_pkg::ACC_W-1:m4vt_pkg::DATA_W-1];
    assign clamp    = !((&top_bits) || !(|top_bits));

    always_comb
    begin
        if (!clamp)
        begin
            word = shifted[m4vt_pkg::DATA_W-1:0];
        end
        else if (shifted[m4vt_pkg::ACC_W-1])
        begin
            word = m4vt_pkg::SAT_MIN;
        end
        else
        begin
            word = m4vt_pkg::SAT_MAX;
        end
    end

endmodule

// ----- design/m4vt_merge.sv -----
// Output stage: gathers the lane words, ORs the clamp flags.
module m4vt_merge #(
    parameter int NLANE = 4
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s2_valid,
    input  m4vt_pkg::word_t      lane_word [NLANE],
    input  logic [NLANE-1:0]     lane_clamp,
    input  logic                 rsp_ready,
    output logic                 load_en,
    output logic                 rsp_valid,
    output m4vt_pkg::word_t      word [m4vt_pkg::NVEC],
    output logic                 sat
);

    m4vt_pkg::word_t fill_word [m4vt_pkg::NVEC];
    m4vt_pkg::word_t word_reg  [m4vt_pkg::NVEC];
    logic            sat_reg;
    logic            valid_reg;
    logic            valid_next;

    // Outputs past the matrix dimension read as zero.
    for (genvar i = 0; i < m4vt_pkg::NVEC; i++)
    begin : g_fill
        if (i < NLANE)
        begin : g_lane
            assign fill_word[i] = lane_word[i];
        end
        else
        begin : g_zero
            assign fill_word[i] = '0;
        end
    end

    assign load_en    = !valid_reg || rsp_ready;
    assign valid_next = load_en ? s2_valid : valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_en)
        begin
            word_reg <= fill_word;
            sat_reg  <= |lane_clamp;
        end
    end

    assign rsp_valid = valid_reg;
    assign word      = word_reg;
    assign sat       = sat_reg;

endmodule

// ----- design/matrix4_vector_transform.sv -----
// 4x4 matrix times 4-vector, signed Q16.16, fixed-point with saturation.
// Request channel (req_valid/req_ready): req_type selects a column load or a
//   transform; column_index picks the column for a load; elem_0..elem_3 carry
//   the column or the vector (x, y, z, w).
// A load beat updates the stored matrix at the accepting edge and produces no
//   response; a transform beat accepted in the next cycle already sees it.
// Response channel (rsp_valid/rsp_ready): out_0..out_3 are the row dot
//   products, saturated to 32 bits; saturated flags any clamped element.
// Pipeline: a transform beat passes the product, sum and output registers
//   before it shows on the response port. Throughput: one beat per cycle
//   while req_ready is high, loads and transforms alike; the four row
//   lanes run side by side, each with one 32x32 multiplier per column.
// Stall: a held response freezes the stages behind it only where they are
//   full; bubbles collapse, so req_ready stays high until the pipe fills.
// Reset: clears all pipeline valid bits and restores the identity matrix.
module matrix4_vector_transform #(
    parameter int DIM       = 4,
    parameter int FRAC_BITS = 16
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    req_valid,
    output logic                    req_ready,
    input  logic                    req_type,
    input  logic [1:0]              column_index,
    input  logic signed [31:0]      elem_0,
    input  logic signed [31:0]      elem_1,
    input  logic signed [31:0]      elem_2,
    input  logic signed [31:0]      elem_3,
    output logic                    rsp_valid,
    input  logic                    rsp_ready,
    output logic signed [31:0]      out_0,
    output logic signed [31:0]      out_1,
    output logic signed [31:0]      out_2,
    output logic signed [31:0]      out_3,
    output logic                    saturated
);

    `include "matrix4_vector_transform_defines.svh"

    // Lanes and terms that can ever be nonzero: rows past the fourth are never
    // output and vector elements past the fourth are zero.
    localparam int NLANE = (DIM < m4vt_pkg::NVEC) ? DIM : m4vt_pkg::NVEC;
    localparam logic [m4vt_pkg::DATA_W-1:0] UNIT = m4vt_pkg::DATA_W'(1) << FRAC_BITS;

    // Matrix stored by columns: mat_reg[column][row].
    m4vt_pkg::word_t mat_reg [DIM][DIM];
    m4vt_pkg::word_t vec     [m4vt_pkg::NVEC];

    m4vt_pkg::word_t    lane_word  [NLANE];
    logic [NLANE-1:0]   lane_clamp;
    m4vt_pkg::word_t    rsp_word   [m4vt_pkg::NVEC];
    m4vt_pkg::pipe_ctrl_t ctrl;

    logic s1_valid_reg;
    logic s1_valid_next;
    logic s2_valid_reg;
    logic s2_valid_next;
    logic out_load;
    logic req_fire;
    logic load_fire;
    logic xform_fire;

    assign vec[0] = elem_0;
    assign vec[1] = elem_1;
    assign vec[2] = elem_2;
    assign vec[3] = elem_3;

    // Each stage takes a new beat when empty or when its successor moves.
    assign ctrl.s2_en = !s2_valid_reg || out_load;
    assign ctrl.s1_en = !s1_valid_reg || ctrl.s2_en;
    assign req_ready  = ctrl.s1_en;

    assign req_fire   = req_valid && req_ready;
    assign load_fire  = req_fire && (req_type == m4vt_pkg::REQ_LOAD);
    assign xform_fire = req_fire && (req_type == m4vt_pkg::REQ_TRANSFORM);

    assign s1_valid_next = ctrl.s1_en ? xform_fire : s1_valid_reg;
    assign s2_valid_next = ctrl.s2_en ? s1_valid_reg : s2_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
            s2_valid_reg <= s2_valid_next;
        end
    end

    // Matrix store. Loads reach only the first four rows; a column at or past
    // DIM is dropped.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int c = 0; c < DIM; c++)
            begin
                for (int r = 0; r < DIM; r++)
                begin
                    mat_reg[c][r] <= (c == r) ? UNIT : '0;
                end
            end
        end
        else
        begin
            for (int c = 0; c < DIM; c++)
            begin
                if (load_fire && (int'(column_index) == c))
                begin
                    for (int r = 0; r < NLANE; r++)
                    begin
                        mat_reg[c][r] <= vec[r];
                    end
                end
            end
        end
    end

    for (genvar r = 0; r < NLANE; r++)
    begin : g_lane
        m4vt_pkg::word_t row_elem [NLANE];
        m4vt_pkg::word_t vec_elem [NLANE];

        for (genvar c = 0; c < NLANE; c++)
        begin : g_term
            assign row_elem[c] = mat_reg[c][r];
            assign vec_elem[c] = vec[c];
        end

        m4vt_lane #(
            .NTERM     (NLANE),
            .FRAC_BITS (FRAC_BITS)
        ) u_lane (
            .clk      (clk),
            .ctrl     (ctrl),
            .row_elem (row_elem),
            .vec_elem (vec_elem),
            .word     (lane_word[r]),
            .clamp    (lane_clamp[r])
        );
    end

    m4vt_merge #(
        .NLANE (NLANE)
    ) u_merge (
        .clk        (clk),
        .rst_n      (rst_n),
        .s2_valid   (s2_valid_reg),
        .lane_word  (lane_word),
        .lane_clamp (lane_clamp),
        .rsp_ready  (rsp_ready),
        .load_en    (out_load),
        .rsp_valid  (rsp_valid),
        .word       (rsp_word),
        .sat        (saturated)
    );

    assign out_0 = rsp_word[0];
    assign out_1 = rsp_word[1];
    assign out_2 = rsp_word[2];
    assign out_3 = rsp_word[3];

    // A load beat never enters the arithmetic pipe.
    `M4VT_ASSERT_NEXT(a_load_no_rsp, load_fire, !s1_valid_reg,
        "load beat entered the pipeline")
    // A transform beat always lands in the product stage.
    `M4VT_ASSERT_NEXT(a_xform_enters, xform_fire, s1_valid_reg,
        "transform beat lost at the product stage")
    // An empty pipe must take a request.
    `M4VT_ASSERT_NOW(a_empty_ready, !s1_valid_reg && !s2_valid_reg && !rsp_valid,
        req_ready, "empty pipeline refused a request")
    // The flag only rises together with a clamped element.
    `M4VT_ASSERT_NOW(a_sat_value, rsp_valid && saturated,
        out_0 == m4vt_pkg::SAT_MAX || out_0 == m4vt_pkg::SAT_MIN ||
        out_1 == m4vt_pkg::SAT_MAX || out_1 == m4vt_pkg::SAT_MIN ||
        out_2 == m4vt_pkg::SAT_MAX || out_2 == m4vt_pkg::SAT_MIN ||
        out_3 == m4vt_pkg::SAT_MAX || out_3 == m4vt_pkg::SAT_MIN,
        "saturated set without a clamped element")

endmodule
